>>> rtl/ipd_pkg.sv
// Shared types and constants for the image packet deframer.
// Holds the event codes, header byte positions, marker patterns and the
// command and status structs between controller and datapath. No dependencies.
package ipd_pkg;

   // Result event codes.
   typedef enum logic [1:0] {
      EV_HEADER      = 2'd0,
      EV_IMAGE_START = 2'd1,
      EV_IMAGE_END   = 2'd2,
      EV_DATA        = 2'd3
   } event_kind_type;

   // Positions of the fields inside the header.
   localparam int HDR_KIND_POS   = 0;
   localparam int HDR_ID_POS     = 1;
   localparam int HDR_SEQ_LO_POS = 5;
   localparam int HDR_SEQ_HI_POS = 6;
   localparam int HDR_LEN_POS    = 7;

   localparam logic [7:0] NODE_KIND_RESET = 8'd1;

   // Marker strings "begin" and "end"; all characters of each are distinct.
   localparam logic [7:0] BEGIN_PAT [5] = '{8'h62, 8'h65, 8'h67, 8'h69, 8'h6e};
   localparam logic [7:0] END_PAT   [3] = '{8'h65, 8'h6e, 8'h64};
   localparam logic [2:0] BEGIN_LEN = 3'd5;
   localparam logic [1:0] END_LEN   = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_byte;
      logic load_hdr;
      logic load_mark;
      logic drain_start;
      logic rd_issue;
      logic rd_capture;
      logic load_word;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hdr_done;
      logic pay_done;
      logic image;
      logic marker_any;
      logic dup;
      logic word_done;
      logic drain_last;
      logic out_free;
   } dp_status_type;

   // One step of the "begin" matcher; it sticks once the whole string is seen.
   function automatic logic [2:0] begin_step(input logic [2:0] m, input logic [7:0] b);
      logic [2:0] r;
      if (m >= BEGIN_LEN) begin
         r = BEGIN_LEN;
      end else if (b == BEGIN_PAT[m]) begin
         r = m + 3'd1;
      end else if (b == BEGIN_PAT[0]) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   // One step of the "end" matcher.
   function automatic logic [1:0] end_step(input logic [1:0] m, input logic [7:0] b);
      logic [1:0] r;
      if (m >= END_LEN) begin
         r = END_LEN;
      end else if (b == END_PAT[m]) begin
         r = m + 2'd1;
      end else if (b == END_PAT[0]) begin
         r = 2'd1;
      end else begin
         r = 2'd0;
      end
      return r;
   endfunction

endpackage

>>> rtl/image_packet_deframer.sv
// Top level of the image packet deframer: byte-serial packet parser with
// header report, sequence gap check, image markers and payload word output.
// Depends on ipd_pkg, ipd_ctrl, ipd_datapath (which holds ipd_ram).
//
// Order: the header beat is loaded from state S_HDR after the last header byte, and a
// marker beat from S_EVAL and then S_MARK after the last payload byte; each waits
// while the sink still holds the previous beat. A data drain reads each buffered byte
// (S_RD), packs it (S_CAP) and loads each 8-byte word (S_WORD), which waits likewise.
// Throughput: payload bytes back to back; the byte input is closed while a result forms.
// Reset is synchronous, active high; it clears control and header state, node kind to 1.
module image_packet_deframer #(
   parameter int HEADER_LEN  = 8,
   parameter int MAX_PAYLOAD = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Byte input channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_source_kind,
   output logic [7:0]  rsp_source_id,
   output logic [15:0] rsp_packet_seq,
   output logic [7:0]  rsp_payload_len,
   output logic        rsp_is_duplicate,
   output logic [15:0] rsp_lost_packets,
   output logic [63:0] rsp_data_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic        rsp_last_of_run,
   // Configuration write channel for image_node_kind.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_image_node_kind
);

   // The controller and the datapath talk only through these two structs.
   ipd_pkg::ctl_cmd_type  cmd;
   ipd_pkg::dp_status_type status;

   // Configuration writes are always taken; the user must issue them only while idle (not enforced here).
   assign csr_ready = 1'b1;

   // The controller owns the byte handshake and decides, one beat at a time,
   // what the datapath does: take a byte, load a header or marker result, or
   // step the payload drain that packs buffered bytes into 8-byte words.
   ipd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the header fields, the sequence check (duplicate
   // flag and count of missing packets), the "begin"/"end" matchers, the
   // payload buffer and the result register that lets a finished beat wait
   // for the sink.
   ipd_datapath #(
      .HEADER_LEN  (HEADER_LEN),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_rx_byte         (req_rx_byte),
      .csr_valid           (csr_valid),
      .csr_image_node_kind (csr_image_node_kind),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_source_kind     (rsp_source_kind),
      .rsp_source_id       (rsp_source_id),
      .rsp_packet_seq      (rsp_packet_seq),
      .rsp_payload_len     (rsp_payload_len),
      .rsp_is_duplicate    (rsp_is_duplicate),
      .rsp_lost_packets    (rsp_lost_packets),
      .rsp_data_word       (rsp_data_word),
      .rsp_valid_bytes     (rsp_valid_bytes),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule

>>> rtl/ipd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the payload buffer. No dependencies.
module ipd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ipd_datapath.sv
// Datapath of the image packet deframer: header registers, sequence check,
// marker matchers, payload buffer, word packer and the result register.
// Depends on ipd_pkg and ipd_ram.
module ipd_datapath #(
   parameter int HEADER_LEN  = 8,
   parameter int MAX_PAYLOAD = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ipd_pkg::ctl_cmd_type  cmd,
   output ipd_pkg::dp_status_type status,
   input  logic [7:0]            req_rx_byte,
   input  logic                  csr_valid,
   input  logic [7:0]            csr_image_node_kind,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_event_kind,
   output logic [7:0]            rsp_source_kind,
   output logic [7:0]            rsp_source_id,
   output logic [15:0]           rsp_packet_seq,
   output logic [7:0]            rsp_payload_len,
   output logic                  rsp_is_duplicate,
   output logic [15:0]           rsp_lost_packets,
   output logic [63:0]           rsp_data_word,
   output logic [3:0]            rsp_valid_bytes,
   output logic                  rsp_last_of_run
);

   localparam int AW = $clog2(MAX_PAYLOAD);

   // Packet state.
   logic [7:0]  node_kind_ff, node_kind_in;
   logic        in_payload_ff, in_payload_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  hdr_kind_ff, hdr_kind_in;
   logic [7:0]  hdr_id_ff, hdr_id_in;
   logic [15:0] hdr_seq_ff, hdr_seq_in;
   logic [7:0]  hdr_len_ff, hdr_len_in;
   logic [15:0] prev_seq_ff, prev_seq_in;
   logic        dup_ff, dup_in;
   logic [15:0] lost_ff, lost_in;
   logic [2:0]  begin_match_ff, begin_match_in;
   logic [1:0]  end_match_ff, end_match_in;
   logic [1:0]  marker_ff, marker_in;

   // Drain state.
   logic [7:0]  rd_ptr_ff, rd_ptr_in;
   logic [3:0]  lane_ff, lane_in;
   logic [63:0] word_ff, word_in;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [7:0]  out_src_kind_ff, out_src_kind_in;
   logic [7:0]  out_src_id_ff, out_src_id_in;
   logic [15:0] out_seq_ff, out_seq_in;
   logic [7:0]  out_len_ff, out_len_in;
   logic        out_dup_ff, out_dup_in;
   logic [15:0] out_lost_ff, out_lost_in;
   logic [63:0] out_word_ff, out_word_in;
   logic [3:0]  out_nbytes_ff, out_nbytes_in;
   logic        out_last_ff, out_last_in;

   logic        image;
   logic [7:0]  cnt_inc;
   logic [7:0]  ptr_inc;
   logic [15:0] seq_diff;
   logic        out_free;
   logic        ram_wr_en;
   logic [7:0]  ram_rd_data;
   logic [7:0]  cap_byte;
   logic [2:0]  begin_next;
   logic [1:0]  end_next;

   assign image    = (hdr_kind_ff == node_kind_ff);
   assign cnt_inc  = byte_count_ff + 8'd1;
   assign ptr_inc  = rd_ptr_ff + 8'd1;
   assign seq_diff = hdr_seq_ff - prev_seq_ff;
   assign out_free = !out_valid_ff || rsp_ready;
   assign begin_next = ipd_pkg::begin_step(begin_match_ff, req_rx_byte);
   assign end_next   = ipd_pkg::end_step(end_match_ff, req_rx_byte);

   assign ram_wr_en = cmd.take_byte && in_payload_ff && image &&
                      (9'(byte_count_ff) < 9'(MAX_PAYLOAD));

   ipd_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (byte_count_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Bytes past the buffer were never stored and read as zero.
   assign cap_byte = (9'(rd_ptr_ff) < 9'(MAX_PAYLOAD)) ? ram_rd_data : 8'd0;

   assign status.hdr_done   = !in_payload_ff && (byte_count_ff == 8'(HEADER_LEN - 1));
   assign status.pay_done   = in_payload_ff && (cnt_inc >= hdr_len_ff);
   assign status.image      = image;
   assign status.marker_any = |marker_ff;
   assign status.dup        = dup_ff;
   assign status.word_done  = (lane_ff == 4'd7) || (ptr_inc == hdr_len_ff);
   assign status.drain_last = (rd_ptr_ff == hdr_len_ff);
   assign status.out_free   = out_free;

   // Byte intake: header capture, sequence check, payload store and matchers.
   always_comb begin
      node_kind_in   = csr_valid ? csr_image_node_kind : node_kind_ff;
      in_payload_in  = in_payload_ff;
      byte_count_in  = byte_count_ff;
      hdr_kind_in    = hdr_kind_ff;
      hdr_id_in      = hdr_id_ff;
      hdr_seq_in     = hdr_seq_ff;
      hdr_len_in     = hdr_len_ff;
      prev_seq_in    = prev_seq_ff;
      dup_in         = dup_ff;
      lost_in        = lost_ff;
      begin_match_in = begin_match_ff;
      end_match_in   = end_match_ff;
      marker_in      = marker_ff;
      if (cmd.take_byte && !in_payload_ff) begin
         case (byte_count_ff)
            8'(ipd_pkg::HDR_KIND_POS):   hdr_kind_in = req_rx_byte;
            8'(ipd_pkg::HDR_ID_POS):     hdr_id_in = req_rx_byte;
            8'(ipd_pkg::HDR_SEQ_LO_POS): hdr_seq_in = {hdr_seq_ff[15:8], req_rx_byte};
            8'(ipd_pkg::HDR_SEQ_HI_POS): hdr_seq_in = {req_rx_byte, hdr_seq_ff[7:0]};
            8'(ipd_pkg::HDR_LEN_POS):    hdr_len_in = req_rx_byte;
            default: ;
         endcase
         byte_count_in = cnt_inc;
         if (status.hdr_done) begin
            // The sequence bytes precede the last header byte, so hdr_seq_ff
            // is already complete here.
            dup_in         = (seq_diff == 16'd0);
            lost_in        = (seq_diff > 16'd1) ? seq_diff - 16'd1 : 16'd0;
            prev_seq_in    = hdr_seq_ff;
            byte_count_in  = 8'd0;
            in_payload_in  = (hdr_len_in != 8'd0);
            begin_match_in = 3'd0;
            end_match_in   = 2'd0;
            marker_in      = 2'd0;
         end
      end else if (cmd.take_byte) begin
         if (image) begin
            begin_match_in = begin_next;
            end_match_in   = end_next;
            marker_in      = marker_ff | {end_next == ipd_pkg::END_LEN,
                                          begin_next == ipd_pkg::BEGIN_LEN};
         end
         byte_count_in = cnt_inc;
         if (status.pay_done) begin
            in_payload_in = 1'b0;
            byte_count_in = 8'd0;
         end
      end
   end

   // Word packer for the payload drain.
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      lane_in   = lane_ff;
      word_in   = word_ff;
      if (cmd.drain_start || cmd.load_word) begin
         lane_in = 4'd0;
         word_in = 64'd0;
      end
      if (cmd.drain_start) begin
         rd_ptr_in = 8'd0;
      end
      if (cmd.rd_capture) begin
         word_in   = word_ff | (64'(cap_byte) << {lane_ff[2:0], 3'b000});
         lane_in   = lane_ff + 4'd1;
         rd_ptr_in = ptr_inc;
      end
   end

   // Result register: loaded only when empty or being taken.
   always_comb begin
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_kind_in     = out_kind_ff;
      out_src_kind_in = out_src_kind_ff;
      out_src_id_in   = out_src_id_ff;
      out_seq_in      = out_seq_ff;
      out_len_in      = out_len_ff;
      out_dup_in      = out_dup_ff;
      out_lost_in     = out_lost_ff;
      out_word_in     = out_word_ff;
      out_nbytes_in   = out_nbytes_ff;
      out_last_in     = out_last_ff;
      if (cmd.load_hdr || cmd.load_mark || cmd.load_word) begin
         out_valid_in    = 1'b1;
         out_src_kind_in = hdr_kind_ff;
         out_src_id_in   = hdr_id_ff;
         out_seq_in      = hdr_seq_ff;
         out_len_in      = hdr_len_ff;
         out_dup_in      = dup_ff;
         out_lost_in     = 16'd0;
         out_word_in     = 64'd0;
         out_nbytes_in   = 4'd0;
         out_last_in     = 1'b1;
         if (cmd.load_hdr) begin
            out_kind_in = ipd_pkg::EV_HEADER;
            out_lost_in = lost_ff;
         end else if (cmd.load_mark) begin
            out_kind_in = marker_ff[1] ? ipd_pkg::EV_IMAGE_END : ipd_pkg::EV_IMAGE_START;
         end else begin
            out_kind_in   = ipd_pkg::EV_DATA;
            out_word_in   = word_ff;
            out_nbytes_in = lane_ff;
            out_last_in   = status.drain_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_kind_ff   <= ipd_pkg::NODE_KIND_RESET;
         in_payload_ff  <= 1'b0;
         byte_count_ff  <= 8'd0;
         hdr_kind_ff    <= 8'd0;
         hdr_id_ff      <= 8'd0;
         hdr_seq_ff     <= 16'd0;
         hdr_len_ff     <= 8'd0;
         prev_seq_ff    <= 16'd0;
         dup_ff         <= 1'b0;
         lost_ff        <= 16'd0;
         begin_match_ff <= 3'd0;
         end_match_ff   <= 2'd0;
         marker_ff      <= 2'd0;
         rd_ptr_ff      <= 8'd0;
         lane_ff        <= 4'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         node_kind_ff   <= node_kind_in;
         in_payload_ff  <= in_payload_in;
         byte_count_ff  <= byte_count_in;
         hdr_kind_ff    <= hdr_kind_in;
         hdr_id_ff      <= hdr_id_in;
         hdr_seq_ff     <= hdr_seq_in;
         hdr_len_ff     <= hdr_len_in;
         prev_seq_ff    <= prev_seq_in;
         dup_ff         <= dup_in;
         lost_ff        <= lost_in;
         begin_match_ff <= begin_match_in;
         end_match_ff   <= end_match_in;
         marker_ff      <= marker_in;
         rd_ptr_ff      <= rd_ptr_in;
         lane_ff        <= lane_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff         <= word_in;
      out_kind_ff     <= out_kind_in;
      out_src_kind_ff <= out_src_kind_in;
      out_src_id_ff   <= out_src_id_in;
      out_seq_ff      <= out_seq_in;
      out_len_ff      <= out_len_in;
      out_dup_ff      <= out_dup_in;
      out_lost_ff     <= out_lost_in;
      out_word_ff     <= out_word_in;
      out_nbytes_ff   <= out_nbytes_in;
      out_last_ff     <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_source_kind  = out_src_kind_ff;
   assign rsp_source_id    = out_src_id_ff;
   assign rsp_packet_seq   = out_seq_ff;
   assign rsp_payload_len  = out_len_ff;
   assign rsp_is_duplicate = out_dup_ff;
   assign rsp_lost_packets = out_lost_ff;
   assign rsp_data_word    = out_word_ff;
   assign rsp_valid_bytes  = out_nbytes_ff;
   assign rsp_last_of_run  = out_last_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_hdr || cmd.load_mark || cmd.load_word) |-> out_free)
      else $error("result register loaded while still holding a beat");

   a_lane_bound: assert property (@(posedge clock) disable iff (reset)
      lane_ff <= 4'd8)
      else $error("word packer lane count out of range");

   a_payload_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_byte && in_payload_ff) |-> (byte_count_ff < hdr_len_ff))
      else $error("payload byte taken beyond the header length");

endmodule

>>> rtl/ipd_ctrl.sv
// Controller of the image packet deframer: sequences byte intake, result
// loads and the payload drain. Depends on ipd_pkg.
module ipd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ipd_pkg::dp_status_type status,
   output ipd_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HDR,
      S_EVAL,
      S_MARK,
      S_RD,
      S_CAP,
      S_WORD
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.take_byte = req_valid && ready_ff;
            if (cmd.take_byte && status.hdr_done) begin
               state_in = S_HDR;
            end else if (cmd.take_byte && status.pay_done) begin
               state_in = S_EVAL;
            end
         end
         S_HDR: begin
            if (status.out_free) begin
               cmd.load_hdr = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EVAL: begin
            if (!status.image) begin
               state_in = S_IDLE;
            end else if (status.marker_any) begin
               state_in = S_MARK;
            end else if (status.dup) begin
               state_in = S_IDLE;
            end else begin
               cmd.drain_start = 1'b1;
               state_in        = S_RD;
            end
         end
         S_MARK: begin
            if (status.out_free) begin
               cmd.load_mark = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_CAP;
         end
         S_CAP: begin
            cmd.rd_capture = 1'b1;
            state_in       = status.word_done ? S_WORD : S_RD;
         end
         S_WORD: begin
            if (status.out_free) begin
               cmd.load_word = 1'b1;
               state_in      = status.drain_last ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      ready_in = (state_in == S_IDLE) && !(state_ff == S_IDLE && cmd.take_byte &&
                 (status.hdr_done || status.pay_done));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_hdr, cmd.load_mark, cmd.load_word}))
      else $error("more than one result load in a cycle");

   a_capture_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_capture |-> $past(cmd.rd_issue))
      else $error("payload capture without a preceding read");

   a_ready_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.rd_issue || cmd.rd_capture || cmd.load_word))
      else $error("byte intake open while draining the payload");

endmodule

>>> tb/tb_image_packet_deframer.sv
// Self-checking testbench for image_packet_deframer: sends whole packets as a byte
// stream and checks every result beat against an in-bench model of the deframer.
// Depends on ipd_pkg and the RTL of image_packet_deframer.
module tb_image_packet_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR_BYTES   = 8;
   localparam int MAX_WORDS   = 32;
   localparam int IDLE_PCT    = 13;
   localparam int SETTLE      = 50;

   // Payload flavors used by the stimulus generator.
   typedef enum int {
      BODY_RANDOM,
      BODY_LETTERS,
      BODY_BEGIN,
      BODY_END,
      BODY_BOTH
   } body_mode_type;

   // One result beat as the deframer should present it.
   typedef struct {
      ipd_pkg::event_kind_type kind;
      logic [7:0]     src_kind;
      logic [7:0]     src_id;
      logic [15:0]    seq;
      logic [7:0]     len;
      logic           dup;
      logic [15:0]    lost;
      logic [63:0]    word;
      logic [3:0]     nbytes;
      logic           last;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_source_kind;
   logic [7:0]  rsp_source_id;
   logic [15:0] rsp_packet_seq;
   logic [7:0]  rsp_payload_len;
   logic        rsp_is_duplicate;
   logic [15:0] rsp_lost_packets;
   logic [63:0] rsp_data_word;
   logic [3:0]  rsp_valid_bytes;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_image_node_kind = 8'd0;

   // Bytes waiting to be sent, and result beats the model says are still owed.
   logic [7:0]  tx_bytes [$];
   frame_beat_type expected_beats [$];
   int          mismatches = 0;
   int          beat_count = 0;
   bit          no_idle = 1'b0;

   // Generator bookkeeping: last sequence number sent, the image node type of the
   // current phase, and how many bytes the current phase has queued so far.
   logic [15:0] gen_seq = 16'd0;
   logic [7:0]  cur_kind = ipd_pkg::NODE_KIND_RESET;
   int          phase_bytes = 0;

   // Deframer model state. It mirrors the block's reset values.
   logic [7:0]  node_kind_m = ipd_pkg::NODE_KIND_RESET;
   logic        in_body = 1'b0;
   logic [7:0]  pos_cnt = 8'd0;
   logic [7:0]  f_kind = 8'd0;
   logic [7:0]  f_id = 8'd0;
   logic [15:0] f_seq = 16'd0;
   logic [7:0]  f_len = 8'd0;
   logic [15:0] last_seq = 16'd0;
   logic        f_dup = 1'b0;
   logic [7:0]  body_buf [256];
   int          begin_run = 0;
   int          end_run = 0;
   bit          saw_begin = 1'b0;
   bit          saw_end = 1'b0;

   image_packet_deframer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_source_kind     (rsp_source_kind),
      .rsp_source_id       (rsp_source_id),
      .rsp_packet_seq      (rsp_packet_seq),
      .rsp_payload_len     (rsp_payload_len),
      .rsp_is_duplicate    (rsp_is_duplicate),
      .rsp_lost_packets    (rsp_lost_packets),
      .rsp_data_word       (rsp_data_word),
      .rsp_valid_bytes     (rsp_valid_bytes),
      .rsp_last_of_run     (rsp_last_of_run),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_image_node_kind (csr_image_node_kind)
   );

   always #2 clock = ~clock;

   // Marker search. The characters of each marker are all distinct, so on a miss
   // the search only has to ask whether this byte starts the marker over.
   function automatic int match_next(input int m, input string pat, input logic [7:0] b);
      if (m >= pat.len()) begin
         return pat.len();
      end
      if (b == pat[m]) begin
         return m + 1;
      end
      return (b == pat[0]) ? 1 : 0;
   endfunction

   // Every beat carries the header fields of the packet in progress.
   function automatic frame_beat_type beat_of(input ipd_pkg::event_kind_type k,
                                              input logic [15:0] lost,
                                              input logic [63:0] w, input logic [3:0] n);
      frame_beat_type bt;
      bt.kind     = k;
      bt.src_kind = f_kind;
      bt.src_id   = f_id;
      bt.seq      = f_seq;
      bt.len      = f_len;
      bt.dup      = f_dup;
      bt.lost     = lost;
      bt.word     = w;
      bt.nbytes   = n;
      bt.last     = 1'b0;
      return bt;
   endfunction

   // Runs one accepted byte through the model and queues the beats it causes.
   function automatic void deframe_byte(input logic [7:0] b);
      frame_beat_type made [$];
      logic [15:0] gap;
      logic [63:0] w;
      int          cnt;
      bit          image;
      if (!in_body) begin
         // Header collection. Bytes 2 to 4 carry nothing of interest.
         case (int'(pos_cnt))
            ipd_pkg::HDR_KIND_POS:   f_kind = b;
            ipd_pkg::HDR_ID_POS:     f_id = b;
            ipd_pkg::HDR_SEQ_LO_POS: f_seq[7:0] = b;
            ipd_pkg::HDR_SEQ_HI_POS: f_seq[15:8] = b;
            ipd_pkg::HDR_LEN_POS:    f_len = b;
            default: ;
         endcase
         pos_cnt = pos_cnt + 8'd1;
         if (int'(pos_cnt) == HDR_BYTES) begin
            // The gap is taken modulo 2^16, so a sequence that goes backwards
            // shows up as a very large number of lost packets.
            gap = f_seq - last_seq;
            f_dup = (gap == 16'd0);
            last_seq = f_seq;
            pos_cnt = 8'd0;
            in_body = (f_len != 8'd0);
            begin_run = 0;
            end_run = 0;
            saw_begin = 1'b0;
            saw_end = 1'b0;
            made.push_back(beat_of(ipd_pkg::EV_HEADER, (gap > 16'd1) ? gap - 16'd1 : 16'd0,
                                   64'd0, 4'd0));
         end
      end else begin
         // Payload of a foreign node is swallowed without a trace.
         image = (f_kind == node_kind_m);
         if (image) begin
            body_buf[pos_cnt] = b;
            begin_run = match_next(begin_run, "begin", b);
            end_run = match_next(end_run, "end", b);
            if (begin_run == 5) begin
               saw_begin = 1'b1;
            end
            if (end_run == 3) begin
               saw_end = 1'b1;
            end
         end
         pos_cnt = pos_cnt + 8'd1;
         if (pos_cnt >= f_len) begin
            in_body = 1'b0;
            pos_cnt = 8'd0;
            if (image) begin
               // An end marker outranks a begin marker, and markers are reported
               // even for a duplicate; only the data words are dropped then.
               if (saw_end) begin
                  made.push_back(beat_of(ipd_pkg::EV_IMAGE_END, 16'd0, 64'd0, 4'd0));
               end else if (saw_begin) begin
                  made.push_back(beat_of(ipd_pkg::EV_IMAGE_START, 16'd0, 64'd0, 4'd0));
               end else if (!f_dup) begin
                  for (int start = 0; start < int'(f_len) && made.size() < MAX_WORDS;
                       start += 8) begin
                     cnt = int'(f_len) - start;
                     if (cnt > 8) begin
                        cnt = 8;
                     end
                     w = 64'd0;
                     for (int j = 0; j < cnt; j++) begin
                        w = w | (64'(body_buf[start + j]) << (8 * j));
                     end
                     made.push_back(beat_of(ipd_pkg::EV_DATA, 16'd0, w, 4'(cnt)));
                  end
               end
            end
            begin_run = 0;
            end_run = 0;
            saw_begin = 1'b0;
            saw_end = 1'b0;
         end
      end
      if (made.size() > 0) begin
         made[made.size() - 1].last = 1'b1;
      end
      foreach (made[i]) begin
         expected_beats.push_back(made[i]);
      end
   endfunction

   // Compares one received beat with the oldest owed beat, field by field.
   function automatic void check_beat(input frame_beat_type want, input frame_beat_type got);
      string       names [10] = '{"event_kind", "source_kind", "source_id", "packet_seq",
                                  "payload_len", "is_duplicate", "lost_packets", "data_word",
                                  "valid_bytes", "last_of_run"};
      logic [63:0] w [10];
      logic [63:0] g [10];
      w = '{64'(want.kind), 64'(want.src_kind), 64'(want.src_id), 64'(want.seq),
            64'(want.len), 64'(want.dup), 64'(want.lost), want.word,
            64'(want.nbytes), 64'(want.last)};
      g = '{64'(got.kind), 64'(got.src_kind), 64'(got.src_id), 64'(got.seq),
            64'(got.len), 64'(got.dup), 64'(got.lost), got.word,
            64'(got.nbytes), 64'(got.last)};
      for (int i = 0; i < 10; i++) begin
         if (w[i] !== g[i]) begin
            mismatches++;
            $display("%0t: beat %0d %s expected %0h actual %0h",
                     $time, beat_count, names[i], w[i], g[i]);
         end
      end
   endfunction

   // Byte driver. The model sees each byte at the edge where it is accepted.
   // A new byte goes out only when the line is free or the current one has just
   // been taken, so req_valid never drops while a byte is waiting.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            deframe_byte(req_rx_byte);
         end
         if (!req_valid || req_ready) begin
            if (tx_bytes.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_rx_byte <= tx_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Backpressure is random except during the quiet phase.
   always @(posedge clock) begin : result_monitor
      frame_beat_type got;
      frame_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind     = ipd_pkg::event_kind_type'(rsp_event_kind);
            got.src_kind = rsp_source_kind;
            got.src_id   = rsp_source_id;
            got.seq      = rsp_packet_seq;
            got.len      = rsp_payload_len;
            got.dup      = rsp_is_duplicate;
            got.lost     = rsp_lost_packets;
            got.word     = rsp_data_word;
            got.nbytes   = rsp_valid_bytes;
            got.last     = rsp_last_of_run;
            if (expected_beats.size() == 0) begin
               mismatches++;
               $display("%0t: beat %0d expected none actual event_kind %0d data_word %h",
                        $time, beat_count, rsp_event_kind, rsp_data_word);
            end else begin
               want = expected_beats.pop_front();
               check_beat(want, got);
            end
            beat_count++;
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Overwrites part of a payload with a marker string.
   task automatic put_text(inout logic [7:0] q [$], input int at, input string s);
      for (int i = 0; i < s.len(); i++) begin
         q[at + i] = s[i];
      end
   endtask

   // Builds a payload. The letter-heavy flavors are there to exercise the
   // marker search with partial and restarted matches such as "bebegin".
   task automatic make_body(input int len, input body_mode_type mode,
                            output logic [7:0] q [$]);
      string letters = "begind";
      int    at;
      q = {};
      for (int i = 0; i < len; i++) begin
         if (mode != BODY_RANDOM && $urandom_range(99) < 70) begin
            q.push_back(8'(letters[$urandom_range(5)]));
         end else begin
            q.push_back(8'($urandom_range(255)));
         end
      end
      if (mode == BODY_BEGIN && len >= 5) begin
         put_text(q, $urandom_range(len - 5), "begin");
      end else if (mode == BODY_END && len >= 3) begin
         put_text(q, $urandom_range(len - 3), "end");
      end else if (mode == BODY_BOTH && len >= 8) begin
         at = $urandom_range(len - 8);
         put_text(q, at, "begin");
         put_text(q, $urandom_range(len - 3, at + 5), "end");
      end
   endtask

   // Queues one packet: header with random filler in the unused bytes, then body.
   task automatic add_packet(input logic [7:0] kind, input logic [7:0] id,
                             input logic [15:0] seq, input logic [7:0] len,
                             input logic [7:0] body [$]);
      tx_bytes.push_back(kind);
      tx_bytes.push_back(id);
      repeat (3) tx_bytes.push_back(8'($urandom_range(255)));
      tx_bytes.push_back(seq[7:0]);
      tx_bytes.push_back(seq[15:8]);
      tx_bytes.push_back(len);
      foreach (body[i]) begin
         tx_bytes.push_back(body[i]);
      end
      gen_seq = seq;
      phase_bytes += HDR_BYTES + body.size();
   endtask

   // A random packet: mostly image packets in order, with duplicates, gaps,
   // jumps and steps backwards mixed in, and foreign nodes now and then.
   task automatic add_random_packet();
      logic [7:0]  kind;
      logic [7:0]  len;
      logic [15:0] seq;
      logic [7:0]  body [$];
      body_mode_type mode;
      int          r;
      kind = ($urandom_range(99) < 65) ? cur_kind : 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 60) begin
         seq = gen_seq + 16'd1;
      end else if (r < 72) begin
         seq = gen_seq;
      end else if (r < 85) begin
         seq = gen_seq + 16'($urandom_range(9, 2));
      end else if (r < 93) begin
         seq = 16'($urandom_range(65535));
      end else begin
         seq = gen_seq - 16'($urandom_range(5, 1));
      end
      r = $urandom_range(99);
      if (r < 10) begin
         len = 8'd0;
      end else if (r < 85) begin
         len = 8'($urandom_range(24, 1));
      end else begin
         len = 8'($urandom_range(80, 25));
      end
      r = $urandom_range(99);
      if (r < 45) begin
         mode = BODY_RANDOM;
      end else if (r < 60) begin
         mode = BODY_LETTERS;
      end else if (r < 75) begin
         mode = BODY_BEGIN;
      end else if (r < 88) begin
         mode = BODY_END;
      end else begin
         mode = BODY_BOTH;
      end
      make_body(int'(len), mode, body);
      add_packet(kind, 8'($urandom_range(255)), seq, len, body);
   endtask

   // Waits until every byte is sent and every owed beat has arrived, then lets
   // the block settle, since a foreign payload ends without any beat.
   task automatic wait_idle();
      while (tx_bytes.size() != 0 || req_valid || expected_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register write; the model takes the new value at the accepting edge.
   task automatic write_node_kind(input logic [7:0] value);
      @(posedge clock);
      csr_valid           <= 1'b1;
      csr_image_node_kind <= value;
      do begin
         @(posedge clock);
      end while (!(csr_valid && csr_ready));
      node_kind_m = value;
      csr_valid <= 1'b0;
   endtask

   // Sequencer: a short directed run at the reset value of the node type, then
   // four phases, each with its own node type. The bytes of a phase are all
   // delivered before the register changes.
   initial begin
      logic [7:0] body [$];
      logic [7:0] phase_kind [4];
      int         budget;
      phase_kind = '{8'hFF, 8'h00, 8'($urandom_range(254, 2)), ipd_pkg::NODE_KIND_RESET};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // First sequence 0 counts as a duplicate; the payload is empty, so only
      // the header beat comes back.
      body = {};
      add_packet(ipd_pkg::NODE_KIND_RESET, 8'h00, 16'h0000, 8'd0, body);
      // Jump to the top sequence value: the largest count of lost packets.
      make_body(3, BODY_END, body);
      add_packet(ipd_pkg::NODE_KIND_RESET, 8'hFF, 16'hFFFF, 8'd3, body);
      // The same sequence again: a duplicate whose begin marker is still reported.
      make_body(5, BODY_BEGIN, body);
      add_packet(ipd_pkg::NODE_KIND_RESET, 8'h5A, 16'hFFFF, 8'd5, body);
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         cur_kind = phase_kind[ph];
         write_node_kind(cur_kind);
         phase_bytes = 0;
         budget = 15;
         // One phase runs with both sides always ready.
         no_idle = (ph == 1);
         if (ph == 3) begin
            // Longest payload: it drains in the most data beats a byte can cause.
            make_body(255, BODY_RANDOM, body);
            add_packet(cur_kind, 8'($urandom_range(255)), gen_seq + 16'd1, 8'd255, body);
         end
         while (phase_bytes < budget) begin
            add_random_packet();
         end
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
